// ===== hdl/dwrw_pkg.sv =====
// ----------------------------------------------------------------------------
// dwrw_pkg
// Shared types, constants and address decode for the DSP work register window.
// ----------------------------------------------------------------------------
package dwrw_pkg;

	localparam int TEMP_DEPTH = 128;
	localparam int MEMS_DEPTH = 32;
	localparam int MIXS_DEPTH = 16;

	// TEMP, MEMS and MIXS share one RAM, in that order
	localparam int RAM_DEPTH = TEMP_DEPTH + MEMS_DEPTH + MIXS_DEPTH;
	localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int DATA_W    = 24;

	localparam logic [10:0] MEMS_BASE = 11'h400;
	localparam logic [10:0] MIXS_BASE = 11'h500;
	localparam logic [10:0] WIN_END   = 11'h580;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic       OP_WRITE  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [1:0]  access_size;
		logic [10:0] offset;
		logic [15:0] write_data;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic              unal;
		logic              hit;
		logic              mix;
		logic [ADDR_W-1:0] addr;
	} dec_t;

	function automatic dec_t decode(input logic [10:0] a);
		dec_t d;
		d.unal = 1'b0;
		d.hit  = 1'b0;
		d.mix  = 1'b0;
		d.addr = '0;
		if (a < WIN_END) begin
			if (a[1]) begin
				d.unal = 1'b1;
			end else if (a < MEMS_BASE) begin
				d.hit  = 32'(a[9:3]) < TEMP_DEPTH;
				d.addr = ADDR_W'(a[9:3]);
			end else if (a < MIXS_BASE) begin
				d.hit  = 32'(a[7:3]) < MEMS_DEPTH;
				d.addr = ADDR_W'(a[7:3]) + ADDR_W'(TEMP_DEPTH);
			end else begin
				d.mix  = 1'b1;
				d.hit  = 32'(a[6:3]) < MIXS_DEPTH;
				d.addr = ADDR_W'(a[6:3]) + ADDR_W'(TEMP_DEPTH + MEMS_DEPTH);
			end
		end
		return d;
	endfunction

endpackage

// ===== hdl/dwrw_ram.sv =====
// ----------------------------------------------------------------------------
// dwrw_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dwrw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 176
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/dwrw_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwrw_ctrl
// Access sequencer: read phase on accept, modify/write phase, result strobe.
// ----------------------------------------------------------------------------
module dwrw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output dwrw_pkg::cmd_t cmd
);
	import dwrw_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_ACCESS
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign cmd.load   = start && !busy_q;
	assign cmd.commit = (state_q == ST_ACCESS);
	assign busy       = busy_q;
	assign done       = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_ACCESS;
						busy_q  <= 1'b1;
					end
				end
				ST_ACCESS: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("access phase did not end in a result strobe");

	a_done_past: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an access phase");

endmodule

// ===== hdl/dwrw_dp.sv =====
// ----------------------------------------------------------------------------
// dwrw_dp
// Datapath: decode, entry read, byte lane merge, write back and result register.
// ----------------------------------------------------------------------------
module dwrw_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  dwrw_pkg::cmd_t cmd,
	input  dwrw_pkg::req_t req,
	output dwrw_pkg::rsp_t rsp
);
	import dwrw_pkg::*;

	req_t              req_q;
	dec_t              dec_q;
	dec_t              dec_in;
	logic [RAM_DEPTH-1:0] vld_q;
	logic              vld_s1;
	logic [DATA_W-1:0] ram_rd;
	logic [DATA_W-1:0] cur;
	logic [DATA_W-1:0] nxt;
	logic [15:0]       fld;
	logic [15:0]       rd_val;
	logic              is_byte;
	logic              do_wr;
	rsp_t              rsp_q;
	logic [7:0]        db;

	assign dec_in = decode(req.offset);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			dec_q <= dec_in;
		end
	end

	dwrw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (do_wr),
		.waddr(dec_q.addr),
		.wdata(nxt),
		.re   (cmd.load),
		.raddr(dec_in.addr),
		.rdata(ram_rd)
	);

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				vld_s1 <= vld_q[dec_in.addr];
			end
			if (do_wr) begin
				vld_q[dec_q.addr] <= 1'b1;
			end
		end
	end

	assign cur     = vld_s1 ? ram_rd : '0;
	assign is_byte = (req_q.access_size == SIZE_BYTE);
	assign do_wr   = cmd.commit && dec_q.hit && (req_q.op == OP_WRITE);
	assign db      = req_q.write_data[7:0];

	always_comb begin
		if (dec_q.mix) begin
			fld = req_q.offset[2] ? cur[19:4] : {12'b0, cur[3:0]};
		end else begin
			fld = req_q.offset[2] ? cur[23:8] : {8'b0, cur[7:0]};
		end
		if (is_byte) begin
			rd_val = req_q.offset[0] ? {8'b0, fld[15:8]} : {8'b0, fld[7:0]};
		end else begin
			rd_val = fld;
		end
	end

	always_comb begin
		nxt = cur;
		if (dec_q.mix) begin
			if (req_q.offset[2]) begin
				if (!is_byte) begin
					nxt[19:4] = req_q.write_data;
				end else if (req_q.offset[0]) begin
					nxt[19:12] = db;
				end else begin
					nxt[11:4] = db;
				end
			end else if (!is_byte || !req_q.offset[0]) begin
				nxt[3:0] = req_q.write_data[3:0];
			end
			nxt[23:20] = 4'b0;
		end else begin
			if (req_q.offset[2]) begin
				if (!is_byte) begin
					nxt[23:8] = req_q.write_data;
				end else if (req_q.offset[0]) begin
					nxt[23:16] = db;
				end else begin
					nxt[15:8] = db;
				end
			end else if (!is_byte || !req_q.offset[0]) begin
				// byte write at +1 leaves the entry alone
				nxt[7:0] = db;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status    <= dec_q.unal;
			rsp_q.read_data <= (dec_q.hit && (req_q.op != OP_WRITE)) ? rd_val : 16'h0;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== hdl/dsp_work_register_window_core.sv =====
// ----------------------------------------------------------------------------
// dsp_work_register_window_core
// Bus access to the TEMP, MEMS and MIXS work registers of a sound DSP.
// ----------------------------------------------------------------------------
// channel   handshake            payload
// request   start / busy         req  (op, access_size, offset, write_data)
// result    done (one cycle)     rsp  (read_data, status)
//
// The accept edge issues the RAM read, the next cycle merges byte lanes and
// writes the entry back through the separate RAM write port; busy holds off a
// new word during that read-modify-write.
// The result strobe follows in the cycle after, while a new word may be taken.
// Reset clears all entries at once through per-entry valid bits; no sweep.
// The receiver cannot stall; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module dsp_work_register_window_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dwrw_pkg::req_t req,
	output logic           done,
	output dwrw_pkg::rsp_t rsp
);
	import dwrw_pkg::*;

	cmd_t cmd;

	dwrw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	dwrw_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

// ===== bench/dsp_work_register_window_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsp_work_register_window_core_tb
// Drives byte, halfword and word accesses into the TEMP, MEMS and MIXS work
// registers and checks every result word against a scoreboard that keeps its
// own copy of the three stores. The run covers lane splitting, unaligned and
// out-of-window accesses, then random traffic under three sender idle rates.
// ----------------------------------------------------------------------------
module dsp_work_register_window_core_tb;

	import dwrw_pkg::*;

	localparam logic       OP_READ    = 1'b0;
	localparam logic [1:0] SIZE_HALF  = 2'd1;
	localparam logic [1:0] SIZE_WORD  = 2'd2;
	localparam logic [1:0] SIZE_THREE = 2'd3;

	localparam int RANDOM_WORDS = 517;	// per idle phase
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 50;

	typedef enum logic [1:0] {AREA_TEMP, AREA_MEMS, AREA_MIXS} area_t;

	class window_scoreboard;
		bit [23:0] temp_mem [TEMP_DEPTH];
		bit [23:0] mems_mem [MEMS_DEPTH];
		bit [23:0] mixs_mem [MIXS_DEPTH];
		rsp_t      pending [$];
		int        errors;

		function rsp_t predict(req_t w);
			rsp_t        res;
			logic [10:0] a;
			bit [23:0]   v;
			logic [15:0] field;
			logic [7:0]  d8;
			area_t       area;
			int          idx;
			bit          hit;
			bit          is_byte;
			bit          mix;
			res     = '0;
			a       = w.offset;
			is_byte = (w.access_size == SIZE_BYTE);
			d8      = w.write_data[7:0];
			if (a >= WIN_END)
				return res;
			if (a[1]) begin
				res.status = 1'b1;
				return res;
			end
			if (a < MEMS_BASE) begin
				area = AREA_TEMP;
				idx  = int'(a) >> 3;
				hit  = idx < TEMP_DEPTH;
			end else if (a < MIXS_BASE) begin
				area = AREA_MEMS;
				idx  = (int'(a) - int'(MEMS_BASE)) >> 3;
				hit  = idx < MEMS_DEPTH;
			end else begin
				area = AREA_MIXS;
				idx  = (int'(a) - int'(MIXS_BASE)) >> 3;
				hit  = idx < MIXS_DEPTH;
			end
			if (!hit)
				return res;
			mix = (area == AREA_MIXS);
			case (area)
				AREA_TEMP: v = temp_mem[idx];
				AREA_MEMS: v = mems_mem[idx];
				default:   v = mixs_mem[idx];
			endcase

			if (w.op != OP_WRITE) begin
				if (mix)
					field = a[2] ? v[19:4] : {12'h000, v[3:0]};
				else
					field = a[2] ? v[23:8] : {8'h00, v[7:0]};
				if (is_byte)
					field = a[0] ? {8'h00, field[15:8]} : {8'h00, field[7:0]};
				res.read_data = field;
				return res;
			end

			if (mix) begin
				if (a[2]) begin
					if (is_byte) begin
						if (a[0])
							v[19:12] = d8;
						else
							v[11:4] = d8;
					end else begin
						v[19:4] = w.write_data;
					end
				end else if (!is_byte || !a[0]) begin
					v[3:0] = w.write_data[3:0];
				end
				v[23:20] = 4'h0;
			end else begin
				if (a[2]) begin
					if (is_byte) begin
						if (a[0])
							v[23:16] = d8;
						else
							v[15:8] = d8;
					end else begin
						v[23:8] = w.write_data;
					end
				end else if (!is_byte || !a[0]) begin
					v[7:0] = d8;
				end
			end
			case (area)
				AREA_TEMP: temp_mem[idx] = v;
				AREA_MEMS: mems_mem[idx] = v;
				default:   mixs_mem[idx] = v;
			endcase
			return res;
		endfunction

		function void note(req_t w);
			pending.push_back(predict(w));
		endfunction

		function void check(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: result word with none pending: read_data %h status %b",
						$time, got.read_data, got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.read_data !== want.read_data) begin
				if (errors < MAX_REPORTS)
					$display("%0t: read_data expected %h actual %h",
						$time, want.read_data, got.read_data);
				errors++;
			end
			if (got.status !== want.status) begin
				if (errors < MAX_REPORTS)
					$display("%0t: status expected %b actual %b",
						$time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	window_scoreboard sb = new;
	int cycles;

	dsp_work_register_window_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result first: a result at the same edge belongs to an older word
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check(rsp);
			if (start && !busy)
				sb.note(req);
		end
	end

	function automatic req_t make_word(logic op, logic [1:0] size, logic [10:0] off,
			logic [15:0] data);
		req_t w;
		w.op          = op;
		w.access_size = size;
		w.offset      = off;
		w.write_data  = data;
		return w;
	endfunction

	function automatic req_t random_word();
		int          pick;
		int          idx;
		logic [10:0] off;
		pick = $urandom_range(99);
		if (pick < 7) begin
			off = 11'($urandom_range(int'(WIN_END), 11'h7FF));
		end else if (pick < 15) begin
			off = 11'($urandom_range(0, int'(WIN_END) - 1)) | 11'h002;
		end else begin
			// half the time stay on a few entries so reads meet earlier writes
			case ($urandom_range(2))
				0: begin
					idx = $urandom_range(1) ? $urandom_range(3) : $urandom_range(TEMP_DEPTH - 1);
					off = 11'(idx << 3);
				end
				1: begin
					idx = $urandom_range(1) ? $urandom_range(3) : $urandom_range(MEMS_DEPTH - 1);
					off = MEMS_BASE + 11'(idx << 3);
				end
				default: begin
					idx = $urandom_range(1) ? $urandom_range(3) : $urandom_range(MIXS_DEPTH - 1);
					off = MIXS_BASE + 11'(idx << 3);
				end
			endcase
			off[2] = 1'($urandom_range(1));
			off[0] = 1'($urandom_range(1));
		end
		return make_word(1'($urandom_range(1)), 2'($urandom_range(3)), off,
			16'($urandom_range(16'hFFFF)));
	endfunction

	task automatic send_word(input req_t w, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int idle_rates [3];
		idle_rates = '{7, 45, 0};
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// TEMP lanes, including the ignored byte write at +1
		send_word(make_word(OP_WRITE, SIZE_WORD,  11'h004, 16'hFFFF), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h004, 16'h0000), 0);
		send_word(make_word(OP_READ,  SIZE_BYTE,  11'h004, 16'h0000), 0);
		send_word(make_word(OP_READ,  SIZE_BYTE,  11'h005, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_BYTE,  11'h000, 16'h00A5), 0);
		send_word(make_word(OP_READ,  SIZE_BYTE,  11'h001, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_BYTE,  11'h001, 16'h005A), 0);
		send_word(make_word(OP_READ,  SIZE_HALF,  11'h000, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_BYTE,  11'h00C, 16'hFF12), 0);
		send_word(make_word(OP_WRITE, SIZE_BYTE,  11'h00D, 16'hFF34), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h00C, 16'h0000), 0);
		// unaligned inside the window
		send_word(make_word(OP_READ,  SIZE_HALF,  11'h002, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_WORD,  11'h006, 16'hFFFF), 0);
		// MEMS last entry, size code three acts as word
		send_word(make_word(OP_WRITE, SIZE_WORD,  11'h4FC, 16'hBEEF), 0);
		send_word(make_word(OP_READ,  SIZE_THREE, 11'h4FD, 16'h0000), 0);
		// MIXS nibble and 16-bit field
		send_word(make_word(OP_WRITE, SIZE_THREE, 11'h500, 16'hFFFF), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h500, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_BYTE,  11'h504, 16'h00C3), 0);
		send_word(make_word(OP_WRITE, SIZE_BYTE,  11'h505, 16'h0096), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h504, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_WORD,  11'h57C, 16'hFFFF), 0);
		send_word(make_word(OP_READ,  SIZE_BYTE,  11'h57D, 16'h0000), 0);
		send_word(make_word(OP_WRITE, SIZE_WORD,  11'h3FC, 16'h0000), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h3F8, 16'h0000), 0);
		// outside the window, bit 1 there does not flag unaligned
		send_word(make_word(OP_WRITE, SIZE_WORD,  11'h580, 16'hFFFF), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h580, 16'h0000), 0);
		send_word(make_word(OP_READ,  SIZE_BYTE,  11'h7FF, 16'h0000), 0);
		send_word(make_word(OP_READ,  SIZE_WORD,  11'h7FA, 16'h0000), 0);

		foreach (idle_rates[p]) begin
			for (int n = 0; n < RANDOM_WORDS; n++)
				send_word(random_word(), idle_rates[p]);
		end
		@(negedge clk);
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== dsp_work_register_window_core.f =====
hdl/dwrw_pkg.sv
hdl/dwrw_ram.sv
hdl/dwrw_ctrl.sv
hdl/dwrw_dp.sv
hdl/dsp_work_register_window_core.sv
bench/dsp_work_register_window_core_tb.sv
